[rtl/extended_gcd_bezout_top_assert.svh]
// assertion macros shared by the gcd datapath modules
`ifndef EXTENDED_GCD_BEZOUT_TOP_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EGCD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("egcd assertion failed");

// next-cycle implication, checked outside reset
`define EGCD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("egcd assertion failed");

`endif

[rtl/egcd_pkg.sv]
package egcd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int GCD_W      = DATA_WIDTH - 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  // controls for the coefficient datapath
  typedef struct packed {
    logic init;
    logic mul_x;
    logic mul_y;
    logic upd_y;
  } coeff_ctrl_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MULX  = 7'b0001000,
    S_MULY  = 7'b0010000,
    S_UPDY  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

endpackage

[rtl/egcd_in_if.sv]
interface egcd_in_if import egcd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] first_value;
  logic signed [DATA_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

[rtl/egcd_out_if.sv]
interface egcd_out_if import egcd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [GCD_W-1:0]      gcd_value;
  logic signed [DATA_WIDTH-1:0] coeff_first;
  logic signed [DATA_WIDTH-1:0] coeff_second;

  modport source (output valid, output gcd_value, output coeff_first, output coeff_second,
                  input ready);
  modport sink   (input valid, input gcd_value, input coeff_first, input coeff_second,
                  output ready);
endinterface

[rtl/egcd_divider.sv]
`include "extended_gcd_bezout_top_assert.svh"

module egcd_divider import egcd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quo,
  output word_t rem
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            rem_r, rem_nxt;
  word_t            quo_r, quo_nxt;
  word_t            divisor_r, divisor_nxt;
  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    shifted     = {rem_r, quo_r[DATA_WIDTH-1]};
    diff        = shifted - {1'b0, divisor_r};
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      rem_nxt     = '0;
      quo_nxt     = dividend;
      divisor_nxt = divisor;
    end else if (busy_r) begin
      if (!diff[DATA_WIDTH]) begin
        rem_nxt = diff[DATA_WIDTH-1:0];
      end else begin
        rem_nxt = shifted[DATA_WIDTH-1:0];
      end
      quo_nxt = {quo_r[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  `EGCD_ASSERT_NOW(a_done_idle, done_r, !busy_r)
  `EGCD_ASSERT_NEXT(a_last_step_done, busy_r && !start && cnt_r == CNT_W'(DATA_WIDTH - 1), done_r)
  `EGCD_ASSERT_NOW(a_rem_below_divisor, done_r, rem_r < divisor_r)

endmodule

[rtl/egcd_coeff.sv]
module egcd_coeff import egcd_pkg::*; (
  input  logic        clk,
  input  coeff_ctrl_t ctrl,
  input  word_t       quot,
  output word_t       prev_x,
  output word_t       prev_y
);

  word_t prev_x_r, prev_x_nxt;
  word_t cur_x_r, cur_x_nxt;
  word_t prev_y_r, prev_y_nxt;
  word_t cur_y_r, cur_y_nxt;
  word_t prod_r, prod_nxt;
  word_t mul_op;

  // one shared multiplier, low half only (coefficients wrap mod 2^width)
  assign mul_op   = ctrl.mul_y ? cur_y_r : cur_x_r;
  assign prod_nxt = quot * mul_op;

  always_comb begin
    prev_x_nxt = prev_x_r;
    cur_x_nxt  = cur_x_r;
    prev_y_nxt = prev_y_r;
    cur_y_nxt  = cur_y_r;
    if (ctrl.init) begin
      prev_x_nxt = word_t'(1);
      cur_x_nxt  = '0;
      prev_y_nxt = '0;
      cur_y_nxt  = word_t'(1);
    end else if (ctrl.mul_y) begin
      prev_x_nxt = cur_x_r;
      cur_x_nxt  = prev_x_r - prod_r;
    end else if (ctrl.upd_y) begin
      prev_y_nxt = cur_y_r;
      cur_y_nxt  = prev_y_r - prod_r;
    end
  end

  always_ff @(posedge clk) begin
    prev_x_r <= prev_x_nxt;
    cur_x_r  <= cur_x_nxt;
    prev_y_r <= prev_y_nxt;
    cur_y_r  <= cur_y_nxt;
    if (ctrl.mul_x || ctrl.mul_y) begin
      prod_r <= prod_nxt;
    end
  end

  assign prev_x = prev_x_r;
  assign prev_y = prev_y_r;

endmodule

[rtl/extended_gcd_bezout_top.sv]
// from input accept to out valid, the sequencer makes one pass per euclid division step (at most 45)
// each pass is a radix-2 division of the magnitudes, then sign fix and coefficient update
// the input is ready only while the sequencer is idle, so it works on one item at a time
// the result sits in an output register, so a new item is taken while it waits
// reset: synchronous active-low rst_n clears the sequencer, divider control and out valid
`include "extended_gcd_bezout_top_assert.svh"

module extended_gcd_bezout_top import egcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  egcd_in_if.sink           in_ch,
  egcd_out_if.source        out_ch
);

  state_t state_r, state_nxt;

  // remainder pair of the euclid recurrence, two's complement
  word_t prev_rv_r, prev_rv_nxt;
  word_t cur_rv_r, cur_rv_nxt;
  // signed quotient and remainder of the current step
  word_t q_r, q_nxt;
  word_t r_r, r_nxt;

  logic  prev_neg, cur_neg;
  word_t prev_mag, cur_mag;
  logic  div_start;
  logic  div_done;
  word_t div_quo, div_rem;

  coeff_ctrl_t cctrl;
  word_t       prev_x, prev_y;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [GCD_W-1:0] gcd_r;
  word_t            cf_r, cs_r;
  logic             load_out;
  word_t            neg_gcd, neg_x, neg_y;

  assign prev_neg = prev_rv_r[DATA_WIDTH-1];
  assign cur_neg  = cur_rv_r[DATA_WIDTH-1];
  // magnitude as unsigned, so the most negative value maps to 2^(w-1)
  assign prev_mag = prev_neg ? (word_t'(0) - prev_rv_r) : prev_rv_r;
  assign cur_mag  = cur_neg ? (word_t'(0) - cur_rv_r) : cur_rv_r;

  assign div_start = (state_r == S_START) && (cur_rv_r != '0);

  egcd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prev_mag),
    .divisor  (cur_mag),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  egcd_coeff u_coeff (
    .clk    (clk),
    .ctrl   (cctrl),
    .quot   (q_r),
    .prev_x (prev_x),
    .prev_y (prev_y)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    prev_rv_nxt = prev_rv_r;
    cur_rv_nxt  = cur_rv_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    cctrl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          prev_rv_nxt = in_ch.first_value;
          cur_rv_nxt  = in_ch.second_value;
          cctrl.init  = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        // zero remainder ends the recurrence
        if (cur_rv_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          // truncating division: quotient sign from both, remainder from dividend
          q_nxt     = (prev_neg ^ cur_neg) ? (word_t'(0) - div_quo) : div_quo;
          r_nxt     = prev_neg ? (word_t'(0) - div_rem) : div_rem;
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        cctrl.mul_x = 1'b1;
        state_nxt   = S_MULY;
      end
      S_MULY: begin
        cctrl.mul_y = 1'b1;
        state_nxt   = S_UPDY;
      end
      S_UPDY: begin
        cctrl.upd_y = 1'b1;
        prev_rv_nxt = cur_rv_r;
        cur_rv_nxt  = r_r;
        state_nxt   = S_START;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // negative gcd flips all three results
  assign neg_gcd = word_t'(0) - prev_rv_r;
  assign neg_x   = word_t'(0) - prev_x;
  assign neg_y   = word_t'(0) - prev_y;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_rv_r <= prev_rv_nxt;
    cur_rv_r  <= cur_rv_nxt;
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    if (load_out) begin
      gcd_r <= prev_neg ? neg_gcd[GCD_W-1:0] : prev_rv_r[GCD_W-1:0];
      cf_r  <= prev_neg ? neg_x : prev_x;
      cs_r  <= prev_neg ? neg_y : prev_y;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.gcd_value    = gcd_r;
  assign out_ch.coeff_first  = cf_r;
  assign out_ch.coeff_second = cs_r;

  `EGCD_ASSERT_NOW(a_fin_zero_rem, state_r == S_FIN, cur_rv_r == '0)
  `EGCD_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIV)
  `EGCD_ASSERT_NOW(a_rem_sign, state_r == S_UPDY, (r_r == '0) || (r_r[DATA_WIDTH-1] == prev_neg))

endmodule
